// ===== src/cartridge_bank_mapper_with_irq_macros.svh =====
// ----------------------------------------------------------------------------
// cartridge bank mapper assertion macros
// concurrent check wrappers shared by the mapper rtl
// ----------------------------------------------------------------------------
`ifndef CARTRIDGE_BANK_MAPPER_WITH_IRQ_MACROS_SVH
`define CARTRIDGE_BANK_MAPPER_WITH_IRQ_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CBM_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CBM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define CBM_ASSERT(lbl, clk, rst_n, prop, msg)
`define CBM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== src/cbm_pkg.sv =====
// ----------------------------------------------------------------------------
// cbm_pkg
// shared types and constants of the cartridge bank mapper
// ----------------------------------------------------------------------------
package cbm_pkg;

	typedef enum logic [2:0] {
		UPD_NONE    = 3'd0,
		UPD_PRG     = 3'd1,
		UPD_CHR_ROM = 3'd2,
		UPD_CHR_RAM = 3'd3,
		UPD_MIRROR  = 3'd4
	} kind_t;

	typedef struct packed {
		logic        action;
		logic [15:0] addr;
		logic [7:0]  data;
		logic [7:0]  cycles;
	} req_t;

	typedef struct packed {
		kind_t       update_kind;
		logic [2:0]  slot;
		logic [11:0] page;
		logic [1:0]  mirror_mode;
		logic        irq_line;
	} upd_t;

	typedef struct packed {
		kind_t       kind;
		logic [2:0]  slot;
		logic [11:0] page;
		logic [1:0]  mirror;
	} bank_res_t;

	localparam logic [15:0] ADDR_PRG_4   = 16'h8010;
	localparam logic [15:0] ADDR_PRG_5   = 16'hA010;
	localparam logic [15:0] ADDR_MIRROR  = 16'h9400;
	localparam logic [15:0] DEC_MASK     = 16'hF00C;
	localparam logic [15:0] DEC_LATCH_LO = 16'hF000;
	localparam logic [15:0] DEC_LATCH_HI = 16'hF004;
	localparam logic [15:0] DEC_CTRL     = 16'hF008;
	localparam logic [3:0]  CHR_HI_FIRST = 4'hB;
	localparam logic [3:0]  CHR_HI_LAST  = 4'hE;
	localparam logic [11:0] PAGE_SW_OFF  = 12'h088;
	localparam logic [11:0] PAGE_SW_ON   = 12'h0C8;
	localparam logic [11:0] PAGE_RAM_0   = 12'h004;
	localparam logic [11:0] PAGE_RAM_1   = 12'h005;
	localparam logic [9:0]  PRESCALE_PERIOD = 10'h072;
	localparam logic [9:0]  PRESCALE_MAX    = 10'd511;
	localparam logic [7:0]  COUNT_TOP       = 8'hFF;

endpackage

// ===== src/cbm_bank.sv =====
// ----------------------------------------------------------------------------
// cbm_bank
// write decode, pattern bank bytes and ram switch
// ----------------------------------------------------------------------------
module cbm_bank (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              special_cart,
	input  cbm_pkg::req_t     req,
	output cbm_pkg::bank_res_t res
);

	logic [7:0]  pb_q [8];
	logic        ram_sw_q;
	logic [15:0] dec;
	logic [3:0]  hi;
	logic [3:0]  hi_off;
	logic        is_chr;
	logic [2:0]  slot;
	logic [7:0]  cur;
	logic [7:0]  new_byte;
	logic [11:0] page;
	logic        sw_off;
	logic        sw_on;

	always_comb begin
		dec      = req.addr & cbm_pkg::DEC_MASK;
		hi       = dec[15:12];
		hi_off   = hi - cbm_pkg::CHR_HI_FIRST;
		is_chr   = hi inside {[cbm_pkg::CHR_HI_FIRST:cbm_pkg::CHR_HI_LAST]};
		slot     = {hi_off[1:0], dec[3]};
		cur      = pb_q[slot];
		new_byte = dec[2] ? {req.data[3:0], cur[3:0]} : {cur[7:4], req.data[3:0]};
		page     = dec[2] ? {req.data[7:4], new_byte} : {4'h0, new_byte};
		sw_off   = special_cart && (page == cbm_pkg::PAGE_SW_OFF);
		sw_on    = special_cart && (page == cbm_pkg::PAGE_SW_ON);
	end

	always_comb begin
		res = '0;
		res.kind = cbm_pkg::UPD_NONE;
		if (!req.action) begin
			if (req.addr == cbm_pkg::ADDR_PRG_4) begin
				res.kind = cbm_pkg::UPD_PRG;
				res.slot = 3'd4;
				res.page = {4'h0, req.data};
			end else if (req.addr == cbm_pkg::ADDR_PRG_5) begin
				res.kind = cbm_pkg::UPD_PRG;
				res.slot = 3'd5;
				res.page = {4'h0, req.data};
			end else if (req.addr == cbm_pkg::ADDR_MIRROR) begin
				res.kind   = cbm_pkg::UPD_MIRROR;
				res.mirror = req.data[1:0];
			end else if (is_chr && !sw_off && !sw_on) begin
				res.slot = slot;
				res.page = page;
				if ((page == cbm_pkg::PAGE_RAM_0) || (page == cbm_pkg::PAGE_RAM_1)) begin
					res.kind = (!ram_sw_q && special_cart) ? cbm_pkg::UPD_CHR_ROM
						: cbm_pkg::UPD_CHR_RAM;
				end else begin
					res.kind = cbm_pkg::UPD_CHR_ROM;
				end
			end
		end
	end

	wire chr_wr = en && !req.action && is_chr && (req.addr != cbm_pkg::ADDR_PRG_4)
		&& (req.addr != cbm_pkg::ADDR_PRG_5) && (req.addr != cbm_pkg::ADDR_MIRROR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				pb_q[i] <= 8'(i);
			end
			ram_sw_q <= 1'b0;
		end else if (chr_wr) begin
			pb_q[slot] <= new_byte;
			if (sw_off) begin
				ram_sw_q <= 1'b0;
			end else if (sw_on) begin
				ram_sw_q <= 1'b1;
			end
		end
	end

endmodule

// ===== src/cbm_irq.sv =====
// ----------------------------------------------------------------------------
// cbm_irq
// interrupt latch, up-counter and cycle prescaler
// ----------------------------------------------------------------------------
module cbm_irq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  cbm_pkg::req_t req,
	output logic          irq_next
);

	logic [7:0] reload_q;
	logic [7:0] count_q;
	logic [1:0] mode_q;
	logic [8:0] pre_q;
	logic       pend_q;

	logic [7:0]  reload_d;
	logic [7:0]  count_d;
	logic [1:0]  mode_d;
	logic [8:0]  pre_d;
	logic        pend_d;
	logic [9:0]  sum;
	logic [9:0]  rem;
	logic [15:0] dec;

	always_comb begin
		reload_d = reload_q;
		count_d  = count_q;
		mode_d   = mode_q;
		pre_d    = pre_q;
		pend_d   = pend_q;
		dec      = req.addr & cbm_pkg::DEC_MASK;
		sum      = {1'b0, pre_q} + {2'b00, req.cycles};
		rem      = sum;
		if (req.action) begin
			if (mode_q[1]) begin
				if (sum >= cbm_pkg::PRESCALE_PERIOD) begin
					rem = sum - cbm_pkg::PRESCALE_PERIOD;
					if (count_q == cbm_pkg::COUNT_TOP) begin
						count_d = reload_q;
						mode_d  = {mode_q[0], mode_q[0]};
						pend_d  = 1'b1;
					end else begin
						count_d = count_q + 8'd1;
					end
				end
				pre_d = (rem > cbm_pkg::PRESCALE_MAX) ? cbm_pkg::PRESCALE_MAX[8:0] : rem[8:0];
			end
		end else if ((req.addr != cbm_pkg::ADDR_PRG_4) && (req.addr != cbm_pkg::ADDR_PRG_5)
			&& (req.addr != cbm_pkg::ADDR_MIRROR)) begin
			if (dec == cbm_pkg::DEC_LATCH_LO) begin
				reload_d = {reload_q[7:4], req.data[3:0]};
			end else if (dec == cbm_pkg::DEC_LATCH_HI) begin
				reload_d = {req.data[3:0], reload_q[3:0]};
			end else if (dec == cbm_pkg::DEC_CTRL) begin
				mode_d = req.data[1:0];
				if (req.data[1]) begin
					count_d = reload_q;
					pre_d   = '0;
				end
				pend_d = 1'b0;
			end
		end
	end

	assign irq_next = pend_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reload_q <= '0;
			count_q  <= '0;
			mode_q   <= '0;
			pre_q    <= '0;
			pend_q   <= 1'b0;
		end else if (en) begin
			reload_q <= reload_d;
			count_q  <= count_d;
			mode_q   <= mode_d;
			pre_q    <= pre_d;
			pend_q   <= pend_d;
		end
	end

endmodule

// ===== src/cartridge_bank_mapper_with_irq.sv =====
// an accepted request waits in the request register, then moves to the update register
// throughput: one request per cycle when upd_stall is low; input and update registers with a
// single logic pass between them, the update register drains while the next request is taken
// reset: arst_n clears pipeline valids, pattern bytes to their slot index, irq state to zero
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_with_irq
// bank mapper top: request register, decode and irq logic, update register
// ----------------------------------------------------------------------------
`include "cartridge_bank_mapper_with_irq_macros.svh"

module cartridge_bank_mapper_with_irq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  cbm_pkg::req_t req,
	output logic          upd_valid,
	input  logic          upd_stall,
	output cbm_pkg::upd_t upd,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic          cfg_data
);

	cbm_pkg::req_t      req_s1;
	logic               valid_s1;
	cbm_pkg::upd_t      upd_s2;
	logic               valid_s2;
	logic               special_q;
	logic               adv;
	logic               accept;
	logic               irq_next;
	cbm_pkg::bank_res_t bank_res;

	assign adv       = valid_s1 && (!valid_s2 || !upd_stall);
	assign req_stall = valid_s1 && !adv;
	assign accept    = req_valid && !req_stall;
	assign cfg_ready = 1'b1;
	assign upd_valid = valid_s2;
	assign upd       = upd_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			special_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			special_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req;
		end
	end

	cbm_bank u_bank (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (adv),
		.special_cart (special_q),
		.req          (req_s1),
		.res          (bank_res)
	);

	cbm_irq u_irq (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.req      (req_s1),
		.irq_next (irq_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			upd_s2   <= '0;
		end else if (adv) begin
			valid_s2           <= 1'b1;
			upd_s2.update_kind <= bank_res.kind;
			upd_s2.slot        <= bank_res.slot;
			upd_s2.page        <= bank_res.page;
			upd_s2.mirror_mode <= bank_res.mirror;
			upd_s2.irq_line    <= irq_next;
		end else if (!upd_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	`CBM_ASSERT(a_no_overrun, clk, arst_n, (valid_s1 && valid_s2 && upd_stall) |-> req_stall, "request taken while pipeline full")
	`CBM_ASSERT_NEXT(a_adv_loads, clk, arst_n, adv, valid_s2, "advanced request gave no update")
	`CBM_ASSERT(a_irq_from_tick, clk, arst_n, $rose(upd_s2.irq_line) |-> $past(adv && req_s1.action), "irq raised without a tick")

endmodule
